>>> src/rls_pkg.sv
// Shared constants and types for the region label statistics block.
package rls_pkg;

   localparam int MAX_LABELS = 4096;
   localparam int MAX_DIM    = 2048;
   localparam int ADDR_W     = $clog2(MAX_LABELS);
   localparam int CLR_W      = $clog2(MAX_LABELS + 1);

   localparam int OPCODE_W = 2;
   localparam int COORD_W  = 11;
   localparam int LABEL_W  = 12;
   localparam int COLOR_W  = 8;
   localparam int LIMIT_W  = 13;
   localparam int COUNT_W  = 32;
   localparam int POS_SUM_W = 48;
   localparam int COL_SUM_W = 40;
   localparam int POS_MEAN_W = 19;
   localparam int COL_MEAN_W = 16;

   // divider dividend is (sum << 8) + count / 2
   localparam int FRAC_W   = 8;
   localparam int DIVIDEND_W = POS_SUM_W + FRAC_W + 1;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

   localparam logic [OPCODE_W-1:0] OP_ACCUMULATE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_QUERY      = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR      = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_UNUSED     = 2'd3;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic [COUNT_W-1:0]   count;
      logic [POS_SUM_W-1:0] row_sum;
      logic [POS_SUM_W-1:0] column_sum;
      logic [COL_SUM_W-1:0] red_sum;
      logic [COL_SUM_W-1:0] green_sum;
      logic [COL_SUM_W-1:0] blue_sum;
   } entry_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [COUNT_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> src/rls_if.sv
// Request and response channel interfaces.
interface rls_req_if;
   import rls_pkg::*;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [COORD_W-1:0]  row;
   logic [COORD_W-1:0]  column;
   logic [LABEL_W-1:0]  label;
   logic [COLOR_W-1:0]  red;
   logic [COLOR_W-1:0]  green;
   logic [COLOR_W-1:0]  blue;
   modport source (output valid, opcode, row, column, label, red, green, blue, input ready);
   modport sink (input valid, opcode, row, column, label, red, green, blue, output ready);
endinterface

interface rls_rsp_if;
   import rls_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  status;
   logic [LABEL_W-1:0]    label_out;
   logic [COUNT_W-1:0]    pixel_count;
   logic [POS_MEAN_W-1:0] mean_row;
   logic [POS_MEAN_W-1:0] mean_column;
   logic [COL_MEAN_W-1:0] mean_red;
   logic [COL_MEAN_W-1:0] mean_green;
   logic [COL_MEAN_W-1:0] mean_blue;
   modport source (output valid, status, label_out, pixel_count, mean_row, mean_column,
                   mean_red, mean_green, mean_blue, input ready);
   modport sink (input valid, status, label_out, pixel_count, mean_row, mean_column,
                 mean_red, mean_green, mean_blue, output ready);
endinterface

>>> src/rls_divider.sv
// Restoring divider, one quotient bit per cycle.
module rls_divider
   import rls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [COUNT_W:0]      rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [COUNT_W-1:0]    dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COUNT_W:0]      shifted;
   logic                  fits;

   // load on start, else one shift-subtract step while busy
   always_comb begin
      shifted = {rem_ff[COUNT_W-1:0], quo_ff[DIVIDEND_W-1]};
      fits    = shifted >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
         cnt_in  = DIV_CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (shifted - {1'b0, dsr_ff}) : shifted;
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

>>> src/region_label_statistics.sv
// Top level: label store, sequencer and shared mean divider.
//
//  channel | dir | handshake        | payload
//  req     | in  | valid / ready    | opcode, row, column, label, red, green, blue
//  rsp     | out | valid / ready    | status, label_out, pixel_count, five means
//  csr     | in  | csr_write_enable | label_count (13 bit)
//
// Accumulate accepts with a store read, then writes the update in ST_ACC; ready returns after.
// Query of a valid label with pixels runs five divisions on one shared divider, each
// through ST_DSTART and ST_DWAIT (start, quotient bits, done).
// Clear and reset sweep the store one label per cycle, over all MAX_LABELS (4096) labels.
// A finished result waits in the output register; a new transaction is taken meanwhile,
// and a later result waits for the register to free up.
module region_label_statistics
   import rls_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   rls_req_if.sink            req_chan,
   rls_rsp_if.source          rsp_chan,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_write_data
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_ACC    = 3'd2;
   localparam logic [2:0] ST_DSTART = 3'd3;
   localparam logic [2:0] ST_DWAIT  = 3'd4;
   localparam logic [2:0] ST_OUT    = 3'd5;

   localparam logic [2:0] FLD_ROW    = 3'd0;
   localparam logic [2:0] FLD_COLUMN = 3'd1;
   localparam logic [2:0] FLD_RED    = 3'd2;
   localparam logic [2:0] FLD_GREEN  = 3'd3;
   localparam logic [2:0] FLD_BLUE   = 3'd4;

   entry_type mem [MAX_LABELS];

   logic [2:0]            state_ff, state_in;
   logic [2:0]            field_ff, field_in;
   logic [CLR_W-1:0]      clr_ff, clr_in;
   logic [LIMIT_W-1:0]    label_count_ff;
   logic [LABEL_W-1:0]    label_ff;
   logic [COORD_W-1:0]    row_ff, column_ff;
   logic [COLOR_W-1:0]    red_ff, green_ff, blue_ff;
   logic                  err_ff, err_in;
   entry_type             rd_ff;
   logic [POS_MEAN_W-1:0] mrow_ff, mrow_in, mcol_ff, mcol_in;
   logic [COL_MEAN_W-1:0] mred_ff, mred_in, mgrn_ff, mgrn_in, mblu_ff, mblu_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_load;

   logic                  req_fire;
   logic [LIMIT_W-1:0]    limit;
   logic                  label_ok;
   logic [ADDR_W-1:0]     rd_addr, acc_addr;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   entry_type             mem_wdata, acc_entry;
   logic [COORD_W-1:0]    row_clamped, column_clamped;
   logic [POS_SUM_W-1:0]  sel_sum;
   logic [POS_SUM_W:0]    row_add, col_add;
   logic [COL_SUM_W:0]    red_add, grn_add, blu_add;
   logic                  out_free;
   logic [DIVIDEND_W-1:0] q;
   logic [POS_MEAN_W-1:0] q_pos;
   logic [COL_MEAN_W-1:0] q_col;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   rls_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // input checks
   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign limit = (label_count_ff > LIMIT_W'(MAX_LABELS)) ? LIMIT_W'(MAX_LABELS)
                                                          : label_count_ff;
   assign label_ok = (req_chan.label != '0) && ({1'b0, req_chan.label} <= limit);
   assign rd_addr  = ADDR_W'(req_chan.label - 1'b1);
   assign acc_addr = ADDR_W'(label_ff - 1'b1);
   assign row_clamped = ({1'b0, req_chan.row} >= (COORD_W+1)'(MAX_DIM))
                        ? COORD_W'(MAX_DIM - 1) : req_chan.row;
   assign column_clamped = ({1'b0, req_chan.column} >= (COORD_W+1)'(MAX_DIM))
                           ? COORD_W'(MAX_DIM - 1) : req_chan.column;

   // saturating accumulate
   always_comb begin
      row_add = {1'b0, rd_ff.row_sum} + (POS_SUM_W+1)'(row_ff);
      col_add = {1'b0, rd_ff.column_sum} + (POS_SUM_W+1)'(column_ff);
      red_add = {1'b0, rd_ff.red_sum} + (COL_SUM_W+1)'(red_ff);
      grn_add = {1'b0, rd_ff.green_sum} + (COL_SUM_W+1)'(green_ff);
      blu_add = {1'b0, rd_ff.blue_sum} + (COL_SUM_W+1)'(blue_ff);
      acc_entry.count      = rd_ff.count + 1'b1;
      acc_entry.row_sum    = row_add[POS_SUM_W] ? '1 : row_add[POS_SUM_W-1:0];
      acc_entry.column_sum = col_add[POS_SUM_W] ? '1 : col_add[POS_SUM_W-1:0];
      acc_entry.red_sum    = red_add[COL_SUM_W] ? '1 : red_add[COL_SUM_W-1:0];
      acc_entry.green_sum  = grn_add[COL_SUM_W] ? '1 : grn_add[COL_SUM_W-1:0];
      acc_entry.blue_sum   = blu_add[COL_SUM_W] ? '1 : blu_add[COL_SUM_W-1:0];
   end

   // sum feeding the divider
   always_comb begin
      unique case (field_ff)
         FLD_ROW:    sel_sum = rd_ff.row_sum;
         FLD_COLUMN: sel_sum = rd_ff.column_sum;
         FLD_RED:    sel_sum = POS_SUM_W'(rd_ff.red_sum);
         FLD_GREEN:  sel_sum = POS_SUM_W'(rd_ff.green_sum);
         FLD_BLUE:   sel_sum = POS_SUM_W'(rd_ff.blue_sum);
         default:    sel_sum = '0;
      endcase
   end

   assign q     = div_rsp.quotient;
   assign q_pos = (q > DIVIDEND_W'({POS_MEAN_W{1'b1}})) ? '1 : q[POS_MEAN_W-1:0];
   assign q_col = (q > DIVIDEND_W'({COL_MEAN_W{1'b1}})) ? '1 : q[COL_MEAN_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      field_in  = field_ff;
      clr_in    = clr_ff;
      err_in    = err_ff;
      mrow_in   = mrow_ff;
      mcol_in   = mcol_ff;
      mred_in   = mred_ff;
      mgrn_in   = mgrn_ff;
      mblu_in   = mblu_ff;
      mem_we    = 1'b0;
      mem_waddr = acc_addr;
      mem_wdata = acc_entry;
      rsp_load  = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = {1'b0, sel_sum, FRAC_W'(0)} + DIVIDEND_W'(rd_ff.count >> 1);
      div_req.divisor  = rd_ff.count;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff[ADDR_W-1:0] ;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(MAX_LABELS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               field_in = FLD_ROW;
               err_in   = !label_ok;
               priority if (req_chan.opcode == OP_CLEAR) begin
                  clr_in   = '0;
                  state_in = ST_CLEAR;
               end else if (req_chan.opcode == OP_UNUSED) begin
                  state_in = ST_IDLE;
               end else if (!label_ok) begin
                  state_in = ST_OUT;
               end else if (req_chan.opcode == OP_ACCUMULATE) begin
                  state_in = ST_ACC;
               end else begin
                  state_in = ST_DSTART;
               end
            end
         end
         ST_ACC: begin
            mem_we   = (rd_ff.count != '1);
            state_in = ST_IDLE;
         end
         ST_DSTART: begin
            if (rd_ff.count == '0) begin
               mrow_in  = '0;
               mcol_in  = '0;
               mred_in  = '0;
               mgrn_in  = '0;
               mblu_in  = '0;
               state_in = ST_OUT;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DWAIT;
            end
         end
         ST_DWAIT: begin
            if (div_rsp.done) begin
               unique case (field_ff)
                  FLD_ROW:    mrow_in = q_pos;
                  FLD_COLUMN: mcol_in = q_pos;
                  FLD_RED:    mred_in = q_col;
                  FLD_GREEN:  mgrn_in = q_col;
                  default:    mblu_in = q_col;
               endcase
               field_in = field_ff + 1'b1;
               state_in = (field_ff == FLD_BLUE) ? ST_OUT : ST_DSTART;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   // label store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (req_fire) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         label_count_ff <= LIMIT_W'(MAX_LABELS);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            label_count_ff <= csr_write_data;
         end
      end
   end

   // transaction and result payload
   always_ff @(posedge clock) begin
      field_ff <= field_in;
      err_ff   <= err_in;
      mrow_ff  <= mrow_in;
      mcol_ff  <= mcol_in;
      mred_ff  <= mred_in;
      mgrn_ff  <= mgrn_in;
      mblu_ff  <= mblu_in;
      if (req_fire) begin
         label_ff  <= req_chan.label;
         row_ff    <= row_clamped;
         column_ff <= column_clamped;
         red_ff    <= req_chan.red;
         green_ff  <= req_chan.green;
         blue_ff   <= req_chan.blue;
      end
      if (rsp_load) begin
         rsp_chan.status      <= err_ff ? STATUS_ERR : STATUS_OK;
         rsp_chan.label_out   <= label_ff;
         rsp_chan.pixel_count <= err_ff ? '0 : rd_ff.count;
         rsp_chan.mean_row    <= err_ff ? '0 : mrow_ff;
         rsp_chan.mean_column <= err_ff ? '0 : mcol_ff;
         rsp_chan.mean_red    <= err_ff ? '0 : mred_ff;
         rsp_chan.mean_green  <= err_ff ? '0 : mgrn_ff;
         rsp_chan.mean_blue   <= err_ff ? '0 : mblu_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

endmodule

>>> src/rls_checker.sv
// Port-level assertions for region_label_statistics, with bind.
module rls_checker
   import rls_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [OPCODE_W-1:0] req_opcode,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_status,
   input logic [COUNT_W-1:0]  rsp_pixel_count,
   input logic [LABEL_W-1:0]  rsp_label_out
);

   // store sweep holds off transactions right after reset
   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready) else $error("ready during reset sweep");

   // accumulate is multi-cycle
   a_acc_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OP_ACCUMULATE |=> !req_ready)
      else $error("ready right after accumulate");

   // error results carry no statistics
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ERR |-> rsp_pixel_count == '0)
      else $error("error result with nonzero count");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_label_out))
      else $error("stalled response changed");

endmodule

bind region_label_statistics rls_checker u_rls_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_opcode      (req_chan.opcode),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_pixel_count (rsp_chan.pixel_count),
   .rsp_label_out   (rsp_chan.label_out)
);

>>> bench/rls_stats_checker.sv
// Checker for region_label_statistics: predicts query and error results and compares them.
module rls_stats_checker
   import rls_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   rls_req_if                 req_mon,
   rls_rsp_if                 rsp_mon,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_write_data,
   output int                 mismatch_count,
   output int                 pending_count
);

   typedef struct {
      logic                  status;
      logic [LABEL_W-1:0]    label_out;
      logic [COUNT_W-1:0]    pixel_count;
      logic [POS_MEAN_W-1:0] mean_row;
      logic [POS_MEAN_W-1:0] mean_column;
      logic [COL_MEAN_W-1:0] mean_red;
      logic [COL_MEAN_W-1:0] mean_green;
      logic [COL_MEAN_W-1:0] mean_blue;
   } stats_result_type;

   // per-label accumulators, absent key means all zero
   entry_type        label_stats[int];
   stats_result_type stats_expected[$];
   logic [LIMIT_W-1:0] valid_limit;

   function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                               longint unsigned cap);
      longint unsigned s;
      s = a + b;
      return (s > cap) ? cap : s;
   endfunction

   // rounded fixed point mean, 8 fraction bits, ties upward
   function automatic longint unsigned fixed_avg(longint unsigned sum, longint unsigned cnt,
                                                 longint unsigned cap);
      longint unsigned q;
      if (cnt == 0) return 0;
      q = ((sum << FRAC_W) + (cnt >> 1)) / cnt;
      return (q > cap) ? cap : q;
   endfunction

   // update the accumulators for one transaction, queue a result when one is due
   task automatic apply_label_op();
      logic [OPCODE_W-1:0] op;
      int                  lbl;
      int                  limit;
      entry_type           e;
      stats_result_type    r;
      op  = req_mon.opcode;
      lbl = int'(req_mon.label);
      limit = (int'(valid_limit) > MAX_LABELS) ? MAX_LABELS : int'(valid_limit);
      r = '{default: '0};
      r.label_out = req_mon.label;
      if (op == OP_CLEAR) begin
         label_stats.delete();
         return;
      end
      if (op == OP_UNUSED) return;
      if (lbl < 1 || lbl > limit) begin
         r.status = STATUS_ERR;
         stats_expected.push_back(r);
         return;
      end
      e = label_stats.exists(lbl) ? label_stats[lbl] : '0;
      if (op == OP_ACCUMULATE) begin
         if (e.count != '1) begin
            e.count      = e.count + 1'b1;
            e.row_sum    = POS_SUM_W'(sat_sum(e.row_sum, req_mon.row, {POS_SUM_W{1'b1}}));
            e.column_sum = POS_SUM_W'(sat_sum(e.column_sum, req_mon.column,
                                              {POS_SUM_W{1'b1}}));
            e.red_sum    = COL_SUM_W'(sat_sum(e.red_sum, req_mon.red, {COL_SUM_W{1'b1}}));
            e.green_sum  = COL_SUM_W'(sat_sum(e.green_sum, req_mon.green,
                                              {COL_SUM_W{1'b1}}));
            e.blue_sum   = COL_SUM_W'(sat_sum(e.blue_sum, req_mon.blue, {COL_SUM_W{1'b1}}));
            label_stats[lbl] = e;
         end
         return;
      end
      r.status      = STATUS_OK;
      r.pixel_count = e.count;
      r.mean_row    = POS_MEAN_W'(fixed_avg(e.row_sum, e.count, {POS_MEAN_W{1'b1}}));
      r.mean_column = POS_MEAN_W'(fixed_avg(e.column_sum, e.count, {POS_MEAN_W{1'b1}}));
      r.mean_red    = COL_MEAN_W'(fixed_avg(e.red_sum, e.count, {COL_MEAN_W{1'b1}}));
      r.mean_green  = COL_MEAN_W'(fixed_avg(e.green_sum, e.count, {COL_MEAN_W{1'b1}}));
      r.mean_blue   = COL_MEAN_W'(fixed_avg(e.blue_sum, e.count, {COL_MEAN_W{1'b1}}));
      stats_expected.push_back(r);
   endtask

   task automatic note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH: %s", what);
   endtask

   // compare one response transaction with the oldest expectation
   task automatic check_result();
      stats_result_type x;
      if (stats_expected.size() == 0) begin
         note_mismatch($sformatf("unexpected response label %0d", rsp_mon.label_out));
         return;
      end
      x = stats_expected.pop_front();
      if (rsp_mon.status !== x.status || rsp_mon.label_out !== x.label_out ||
          rsp_mon.pixel_count !== x.pixel_count || rsp_mon.mean_row !== x.mean_row ||
          rsp_mon.mean_column !== x.mean_column || rsp_mon.mean_red !== x.mean_red ||
          rsp_mon.mean_green !== x.mean_green || rsp_mon.mean_blue !== x.mean_blue)
         note_mismatch($sformatf({"exp st=%0d lbl=%0d cnt=%0d r=%h c=%h R=%h G=%h B=%h | ",
            "got st=%0d lbl=%0d cnt=%0d r=%h c=%h R=%h G=%h B=%h"},
            x.status, x.label_out, x.pixel_count, x.mean_row, x.mean_column,
            x.mean_red, x.mean_green, x.mean_blue,
            rsp_mon.status, rsp_mon.label_out, rsp_mon.pixel_count, rsp_mon.mean_row,
            rsp_mon.mean_column, rsp_mon.mean_red, rsp_mon.mean_green, rsp_mon.mean_blue));
   endtask

   initial mismatch_count = 0;
   initial pending_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         label_stats.delete();
         stats_expected.delete();
         valid_limit = LIMIT_W'(MAX_LABELS);
      end else begin
         if (csr_write_enable) valid_limit = csr_write_data;
         if (req_mon.valid && req_mon.ready) apply_label_op();
         if (rsp_mon.valid && rsp_mon.ready) check_result();
      end
      pending_count <= stats_expected.size();
   end

endmodule

>>> bench/region_label_statistics_tb.sv
// Testbench top for region_label_statistics: clock, stimulus, watchdog and verdict.
module region_label_statistics_tb;
   import rls_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [LIMIT_W-1:0] csr_write_data = '0;
   int                 mismatch_count;
   int                 pending_count;
   int                 idle_cycles = 0;
   bit                 hold_off_request = 0;
   int                 cur_limit = MAX_LABELS;

   rls_req_if req_chan();
   rls_rsp_if rsp_chan();

   region_label_statistics dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   rls_stats_checker checker_inst (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   always #5 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int p;
      p = $urandom_range(99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // drive one request transaction and wait for it to be taken
   task automatic send_pixel_op(logic [OPCODE_W-1:0] op, int lbl, int r, int c,
                                int rd, int gr, int bl);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_chan.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.opcode <= op;
      req_chan.label  <= LABEL_W'(lbl);
      req_chan.row    <= COORD_W'(r);
      req_chan.column <= COORD_W'(c);
      req_chan.red    <= COLOR_W'(rd);
      req_chan.green  <= COLOR_W'(gr);
      req_chan.blue   <= COLOR_W'(bl);
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // wait for every result, then long enough for a clear sweep, then write label_count
   task automatic set_label_limit(int v);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (MAX_LABELS + 400) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= LIMIT_W'(v);
      cur_limit = v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // labels mostly from a small pool so they gather pixels, some anywhere
   function automatic int pick_label();
      int top;
      top = (cur_limit < 1) ? 1 : ((cur_limit > 12) ? 12 : cur_limit);
      if ($urandom_range(9) < 7) return $urandom_range(1, top);
      if ($urandom_range(9) < 2) return 0;
      return $urandom_range(0, 4095);
   endfunction

   task automatic random_phase(int n);
      int p;
      logic [OPCODE_W-1:0] op;
      repeat (n) begin
         p = $urandom_range(199);
         if (p < 160) op = OP_ACCUMULATE;
         else if (p < 190) op = OP_QUERY;
         else if (p < 198) op = OP_UNUSED;
         else op = OP_CLEAR;
         send_pixel_op(op, pick_label(), $urandom_range(2047), $urandom_range(2047),
                       $urandom_range(255), $urandom_range(255), $urandom_range(255));
      end
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      bit held;
      held = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_request && !held) begin
            held = 1;
            rsp_chan.ready <= 1'b0;
            repeat (3000) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if ($urandom_range(3) != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap_length() + 1) @(posedge clock);
         end
      end
   end

   // watchdog: cycles with no transaction on any port
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 40000) begin
         $display("region_label_statistics test failed");
         $finish;
      end
   end

   initial begin
      req_chan.valid  = 1'b0;
      req_chan.opcode = OP_ACCUMULATE;
      req_chan.label  = '0;
      req_chan.row    = '0;
      req_chan.column = '0;
      req_chan.red    = '0;
      req_chan.green  = '0;
      req_chan.blue   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every opcode, empty label, bad labels, clear
      send_pixel_op(OP_QUERY, 7, 0, 0, 0, 0, 0);
      send_pixel_op(OP_ACCUMULATE, 1, 2047, 2047, 255, 255, 255);
      send_pixel_op(OP_ACCUMULATE, 1, 0, 0, 0, 0, 0);
      send_pixel_op(OP_ACCUMULATE, 1, 0, 1, 0, 0, 1);
      send_pixel_op(OP_QUERY, 1, 0, 0, 0, 0, 0);
      send_pixel_op(OP_ACCUMULATE, 4095, 2047, 0, 255, 0, 128);
      send_pixel_op(OP_QUERY, 4095, 2047, 2047, 255, 255, 255);
      send_pixel_op(OP_ACCUMULATE, 0, 5, 6, 7, 8, 9);
      send_pixel_op(OP_QUERY, 0, 0, 0, 0, 0, 0);
      send_pixel_op(OP_UNUSED, 1, 2047, 2047, 255, 255, 255);
      send_pixel_op(OP_QUERY, 1, 0, 0, 0, 0, 0);
      send_pixel_op(OP_CLEAR, 4095, 2047, 2047, 255, 255, 255);
      send_pixel_op(OP_QUERY, 1, 0, 0, 0, 0, 0);
      send_pixel_op(OP_QUERY, 4095, 0, 0, 0, 0, 0);
      set_label_limit(1);
      send_pixel_op(OP_ACCUMULATE, 2, 1, 1, 1, 1, 1);
      send_pixel_op(OP_ACCUMULATE, 1, 1, 2, 3, 4, 5);
      send_pixel_op(OP_QUERY, 1, 0, 0, 0, 0, 0);
      send_pixel_op(OP_QUERY, 2, 0, 0, 0, 0, 0);

      // random phases over several limits
      random_phase(200);
      set_label_limit(0);
      hold_off_request = 1;
      random_phase(150);
      set_label_limit(8191);
      random_phase(250);
      set_label_limit(16);
      random_phase(250);
      set_label_limit(4096);
      random_phase(250);
      set_label_limit($urandom_range(2, 4095));
      random_phase(250);
      set_label_limit(5);
      random_phase(250);

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (MAX_LABELS + 400) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("region_label_statistics test passed");
      else
         $display("region_label_statistics test failed");
      $finish;
   end

endmodule

>>> filelist.f
src/rls_pkg.sv
src/rls_if.sv
src/rls_divider.sv
src/region_label_statistics.sv
src/rls_checker.sv
bench/rls_stats_checker.sv
bench/region_label_statistics_tb.sv
